// File: sv/sle_pkg.sv
// Package: transaction types, opcodes, status codes and cell command for the list engine.
package sle_pkg;

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_DELETE  = 3'd1;
  localparam logic [2:0] OP_LOCATE  = 3'd2;
  localparam logic [2:0] OP_GET     = 3'd3;
  localparam logic [2:0] OP_REVERSE = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_POS   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [6:0]         position;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [6:0]         found_position;
    logic [6:0]         count;
    logic               is_empty;
  } out_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic rev_load;
    logic rev_step;
    logic phase;
    logic scan_get;
    logic scan_loc;
  } cmd_t;

endpackage

// File: sv/sle_cell.sv
// One list cell: holds one entry and its reverse tag, shifts, swaps and passes the scan token.
module sle_cell #(
  parameter int WIDTH = 32,
  parameter int CW    = 7,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sle_pkg::cmd_t    cmd,
  input  logic [CW-1:0]    pos_idx,
  input  logic [CW-1:0]    fill,
  input  logic [WIDTH-1:0] key,
  input  logic [WIDTH-1:0] left_entry,
  input  logic [CW-1:0]    left_tag,
  input  logic [WIDTH-1:0] right_entry,
  input  logic [CW-1:0]    right_tag,
  input  logic             left_swap,
  output logic [WIDTH-1:0] entry,
  output logic [CW-1:0]    tag,
  output logic             swap_out,
  input  logic             tok_in_v,
  input  logic             tok_in_hit,
  input  logic [WIDTH-1:0] tok_in_elem,
  input  logic [CW-1:0]    tok_in_fpos,
  output logic             tok_v,
  output logic             tok_hit,
  output logic [WIDTH-1:0] tok_elem,
  output logic [CW-1:0]    tok_fpos
);
  import sle_pkg::*;

  localparam logic          ODD   = 1'((IDX % 2) != 0);
  localparam logic [CW-1:0] MY    = CW'(IDX);
  localparam logic [CW-1:0] MY_P1 = CW'(IDX + 1);

  logic [WIDTH-1:0] entry_r, entry_nxt;
  logic [CW-1:0]    tag_r, tag_nxt;
  logic             tok_v_r;
  logic             tok_hit_r, tok_hit_nxt;
  logic [WIDTH-1:0] tok_elem_r, tok_elem_nxt;
  logic [CW-1:0]    tok_fpos_r, tok_fpos_nxt;

  assign swap_out = cmd.rev_step && (ODD == cmd.phase) && (MY_P1 < fill) && (tag_r < right_tag);

  always_comb begin
    entry_nxt = entry_r;
    tag_nxt   = tag_r;
    if (cmd.ins) begin
      if (MY == pos_idx) begin
        entry_nxt = key;
      end else if (MY > pos_idx) begin
        entry_nxt = left_entry;
      end
    end else if (cmd.del) begin
      if (MY >= pos_idx) begin
        entry_nxt = right_entry;
      end
    end else if (cmd.rev_load) begin
      tag_nxt = MY;
    end else if (swap_out) begin
      entry_nxt = right_entry;
      tag_nxt   = right_tag;
    end else if (left_swap) begin
      entry_nxt = left_entry;
      tag_nxt   = left_tag;
    end
  end

  always_comb begin
    tok_hit_nxt  = tok_in_hit;
    tok_elem_nxt = tok_in_elem;
    tok_fpos_nxt = tok_in_fpos;
    if (tok_in_v) begin
      if (cmd.scan_get && (MY == pos_idx)) begin
        tok_elem_nxt = entry_r;
      end
      if (cmd.scan_loc && !tok_in_hit && (MY < fill) && (entry_r == key)) begin
        tok_hit_nxt  = 1'b1;
        tok_fpos_nxt = MY_P1;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r    <= entry_nxt;
    tag_r      <= tag_nxt;
    tok_hit_r  <= tok_hit_nxt;
    tok_elem_r <= tok_elem_nxt;
    tok_fpos_r <= tok_fpos_nxt;
    if (!rst_n) begin
      tok_v_r <= 1'b0;
    end else begin
      tok_v_r <= tok_in_v;
    end
  end

  assign entry    = entry_r;
  assign tag      = tag_r;
  assign tok_v    = tok_v_r;
  assign tok_hit  = tok_hit_r;
  assign tok_elem = tok_elem_r;
  assign tok_fpos = tok_fpos_r;

endmodule

// File: sv/sequential_list_engine.sv
// Top level: fixed-capacity ordered list built as a chain of cells with a sequencing controller.
//
//  channel  ports                          direction  payload
//  input    in_valid, in_stall, in_data    in         sle_pkg::in_t
//  result   out_valid, out_stall, out_data out        sle_pkg::out_t
//
// One transaction at a time. Insert, clear, unused opcodes, rejected positions and reverse
// of at most one entry go from S_EXEC straight to S_DONE; get, delete and locate pass
// through S_SCAN while the scan token walks every cell; a longer reverse passes through
// S_REV for the odd-even swap rounds over the cells. The next transaction can be accepted
// in the same cycle as the result appears. Reset empties the list; entries need no
// clearing. The next transaction is accepted while a result waits under out_stall.
module sequential_list_engine #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sle_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output sle_pkg::out_t out_data
);
  import sle_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 7) ? CW : 7;
  localparam int EW = PW + 1;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SCAN, S_REV, S_DONE} state_t;

  state_t           state_r;
  logic [2:0]       op_r;
  logic [6:0]       pos_r;
  logic [WIDTH-1:0] key_r;
  logic [CW-1:0]    fill_r;
  logic [CW-1:0]    rnd_r;
  logic [1:0]       status_r;
  logic [31:0]      elem_r;
  logic [CW-1:0]    fpos_r;
  out_t             out_r;
  logic             out_valid_r;

  cmd_t             cmd;
  logic             tok_start;
  logic [PW-1:0]    pos_w;
  logic [CW-1:0]    pos_idx;
  logic             ins_ok;
  logic             rd_ok;
  logic             full;

  logic [WIDTH-1:0] entry   [DEPTH];
  logic [CW-1:0]    tag     [DEPTH];
  logic             swap    [DEPTH];
  logic             tok_v   [DEPTH];
  logic             tok_hit [DEPTH];
  logic [WIDTH-1:0] tok_elem[DEPTH];
  logic [CW-1:0]    tok_fpos[DEPTH];

  logic signed [WIDTH-1:0] tok_elem_s;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign pos_w   = PW'(pos_r);
  assign pos_idx = CW'(pos_w - PW'(1));
  assign full    = (fill_r == CW'(DEPTH));
  assign ins_ok  = (pos_r != 7'd0) && (EW'(pos_r) <= EW'(fill_r) + EW'(1)) && !full;
  assign rd_ok   = (pos_r != 7'd0) && (EW'(pos_r) <= EW'(fill_r));

  assign tok_elem_s = $signed(tok_elem[DEPTH-1]);

  always_comb begin
    cmd          = '0;
    tok_start    = 1'b0;
    cmd.scan_get = (op_r == OP_GET) || (op_r == OP_DELETE);
    cmd.scan_loc = (op_r == OP_LOCATE);
    unique case (state_r)
      S_EXEC: begin
        case (op_r)
          OP_INSERT:         cmd.ins = ins_ok;
          OP_DELETE, OP_GET: tok_start = rd_ok;
          OP_LOCATE:         tok_start = 1'b1;
          OP_REVERSE:        cmd.rev_load = 1'b1;
          default:           ;
        endcase
      end
      S_SCAN: begin
        cmd.del = tok_v[DEPTH-1] && (op_r == OP_DELETE);
      end
      S_REV: begin
        cmd.rev_step = 1'b1;
        cmd.phase    = rnd_r[0];
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] l_entry, r_entry;
    logic [CW-1:0]    l_tag, r_tag;
    logic             l_swap;
    logic             t_v, t_hit;
    logic [WIDTH-1:0] t_elem;
    logic [CW-1:0]    t_fpos;

    if (i == 0) begin : g_first
      assign l_entry = '0;
      assign l_tag   = '0;
      assign l_swap  = 1'b0;
      assign t_v     = tok_start;
      assign t_hit   = 1'b0;
      assign t_elem  = '0;
      assign t_fpos  = '0;
    end else begin : g_mid
      assign l_entry = entry[i-1];
      assign l_tag   = tag[i-1];
      assign l_swap  = swap[i-1];
      assign t_v     = tok_v[i-1];
      assign t_hit   = tok_hit[i-1];
      assign t_elem  = tok_elem[i-1];
      assign t_fpos  = tok_fpos[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_entry = entry[i];
      assign r_tag   = '0;
    end else begin : g_next
      assign r_entry = entry[i+1];
      assign r_tag   = tag[i+1];
    end

    sle_cell #(
      .WIDTH(WIDTH),
      .CW   (CW),
      .IDX  (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .pos_idx    (pos_idx),
      .fill       (fill_r),
      .key        (key_r),
      .left_entry (l_entry),
      .left_tag   (l_tag),
      .right_entry(r_entry),
      .right_tag  (r_tag),
      .left_swap  (l_swap),
      .entry      (entry[i]),
      .tag        (tag[i]),
      .swap_out   (swap[i]),
      .tok_in_v   (t_v),
      .tok_in_hit (t_hit),
      .tok_in_elem(t_elem),
      .tok_in_fpos(t_fpos),
      .tok_v      (tok_v[i]),
      .tok_hit    (tok_hit[i]),
      .tok_elem   (tok_elem[i]),
      .tok_fpos   (tok_fpos[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= in_data.opcode;
            pos_r    <= in_data.position;
            key_r    <= WIDTH'($unsigned(in_data.value));
            status_r <= ST_OK;
            elem_r   <= '0;
            fpos_r   <= '0;
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (op_r)
            OP_INSERT: begin
              state_r <= S_DONE;
              if (!((pos_r != 7'd0) && (EW'(pos_r) <= EW'(fill_r) + EW'(1)))) begin
                status_r <= ST_BAD_POS;
              end else if (full) begin
                status_r <= ST_FULL;
              end else begin
                fill_r <= fill_r + CW'(1);
              end
            end
            OP_DELETE, OP_GET: begin
              if (rd_ok) begin
                state_r <= S_SCAN;
              end else begin
                status_r <= ST_BAD_POS;
                state_r  <= S_DONE;
              end
            end
            OP_LOCATE: begin
              state_r <= S_SCAN;
            end
            OP_REVERSE: begin
              rnd_r <= '0;
              if (fill_r > CW'(1)) begin
                state_r <= S_REV;
              end else begin
                state_r <= S_DONE;
              end
            end
            OP_CLEAR: begin
              fill_r  <= '0;
              state_r <= S_DONE;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_SCAN: begin
          if (tok_v[DEPTH-1]) begin
            state_r <= S_DONE;
            if (op_r == OP_LOCATE) begin
              if (tok_hit[DEPTH-1]) begin
                fpos_r <= tok_fpos[DEPTH-1];
              end else begin
                status_r <= ST_NOT_FOUND;
              end
            end else begin
              elem_r <= 32'(tok_elem_s);
              if (op_r == OP_DELETE) begin
                fill_r <= fill_r - CW'(1);
              end
            end
          end
        end
        S_REV: begin
          rnd_r <= rnd_r + CW'(1);
          if (rnd_r == fill_r - CW'(1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_r.status         <= status_r;
            out_r.element        <= $signed(elem_r);
            out_r.found_position <= 7'(fpos_r);
            out_r.count          <= 7'(fill_r);
            out_r.is_empty       <= (fill_r == '0);
            out_valid_r          <= 1'b1;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
